// ===== rtl/core/gbk_pkg.sv =====
// ----------------------------------------------------------------------------
// gbk_pkg
// Types and constants of the group-by-key reorder block.
// ----------------------------------------------------------------------------
package gbk_pkg;

	localparam int ITEM_CAP = 64;
	localparam int IDX_W    = $clog2(ITEM_CAP);
	localparam int CNT_W    = IDX_W + 1;
	localparam int KEY_W    = 16;
	localparam int PAY_W    = 32;

	typedef struct packed {
		logic [KEY_W-1:0] item_key;
		logic [PAY_W-1:0] item_payload;
		logic             item_last;
	} item_word_t;

	typedef struct packed {
		logic [KEY_W-1:0] out_key;
		logic [PAY_W-1:0] out_payload;
		logic             out_last;
		logic             overflow;
	} result_word_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RD_I,
		S_WANT,
		S_ISSUE,
		S_CMP,
		S_SWAP,
		S_O_RD,
		S_O_LD,
		S_O_WAIT
	} gbk_state_t;

endpackage

// ===== rtl/core/group_by_key_reorder.sv =====
// ----------------------------------------------------------------------------
// group_by_key_reorder
// Loads a list of keyed words, groups equal keys in place, streams it out.
// ----------------------------------------------------------------------------
// Loading takes one word per cycle, up to ITEM_CAP words; words beyond that
// are dropped and flagged on every result of the list. A word with item_last
// ends the list. Grouping runs on one entry memory with two read ports and
// one write port: each anchor i is read, then each pair (i, j) is read and
// compared, and a swap writes its second entry in a further step. Each result
// is read, registered and held while result_stall is high. No word is taken
// while a list is being grouped or streamed out.
module group_by_key_reorder import gbk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  item_word_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_word_t result
);

	entry_t mem_q [ITEM_CAP];
	entry_t rd_a_q, rd_b_q;

	gbk_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] i_q, i_d;
	logic [CNT_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] slot_q, slot_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic             ovf_q, ovf_d;
	logic [KEY_W-1:0] want_q, want_d;
	logic             rvalid_q, rvalid_d;
	result_word_t     res_q, res_d;

	logic             rd_en;
	logic [IDX_W-1:0] raddr_a, raddr_b;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic [CNT_W-1:0] j_nx, i_nx, k_nx;

	assign j_nx = j_q + CNT_W'(1);
	assign i_nx = i_q + CNT_W'(1);
	assign k_nx = k_q + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			ovf_q    <= ovf_d;
			rvalid_q <= rvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q    <= i_d;
		j_q    <= j_d;
		slot_q <= slot_d;
		k_q    <= k_d;
		want_q <= want_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		ovf_d    = ovf_q;
		rvalid_d = rvalid_q;
		i_d      = i_q;
		j_d      = j_q;
		slot_d   = slot_q;
		k_d      = k_q;
		want_d   = want_q;
		res_d    = res_q;
		rd_en    = 1'b0;
		raddr_a  = j_q[IDX_W-1:0];
		raddr_b  = slot_q[IDX_W-1:0];
		we       = 1'b0;
		waddr    = count_q[IDX_W-1:0];
		wdata    = '{key: item.item_key, payload: item.item_payload};
		case (state_q)
			S_LOAD: begin
				if (item_valid) begin
					if (count_q < CNT_W'(ITEM_CAP)) begin
						we      = 1'b1;
						count_d = count_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (item.item_last) begin
						i_d     = '0;
						state_d = S_RD_I;
					end
				end
			end
			S_RD_I: begin
				if (i_nx >= count_q) begin
					k_d     = '0;
					state_d = S_O_RD;
				end else begin
					rd_en   = 1'b1;
					raddr_a = i_q[IDX_W-1:0];
					state_d = S_WANT;
				end
			end
			S_WANT: begin
				want_d  = rd_a_q.key;
				j_d     = i_nx;
				slot_d  = i_nx;
				state_d = S_ISSUE;
			end
			S_ISSUE: begin
				rd_en   = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (rd_a_q.key == want_q && j_q != slot_q) begin
					we      = 1'b1;
					waddr   = slot_q[IDX_W-1:0];
					wdata   = rd_a_q;
					slot_d  = slot_q + CNT_W'(1);
					state_d = S_SWAP;
				end else begin
					if (rd_a_q.key == want_q) begin
						slot_d = slot_q + CNT_W'(1);
					end
					j_d = j_nx;
					if (j_nx >= count_q) begin
						i_d     = i_nx;
						state_d = S_RD_I;
					end else begin
						state_d = S_ISSUE;
					end
				end
			end
			S_SWAP: begin
				we    = 1'b1;
				waddr = j_q[IDX_W-1:0];
				wdata = rd_b_q;
				j_d   = j_nx;
				if (j_nx >= count_q) begin
					i_d     = i_nx;
					state_d = S_RD_I;
				end else begin
					state_d = S_ISSUE;
				end
			end
			S_O_RD: begin
				rd_en   = 1'b1;
				raddr_a = k_q[IDX_W-1:0];
				state_d = S_O_LD;
			end
			S_O_LD: begin
				res_d.out_key     = rd_a_q.key;
				res_d.out_payload = rd_a_q.payload;
				res_d.out_last    = (k_nx == count_q);
				res_d.overflow    = ovf_q;
				rvalid_d          = 1'b1;
				state_d           = S_O_WAIT;
			end
			S_O_WAIT: begin
				if (!result_stall) begin
					rvalid_d = 1'b0;
					if (k_nx == count_q) begin
						count_d = '0;
						ovf_d   = 1'b0;
						state_d = S_LOAD;
					end else begin
						k_d     = k_nx;
						state_d = S_O_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	assign item_stall   = (state_q != S_LOAD);
	assign result_valid = rvalid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	a_no_result_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall |-> !result_valid)
		else $error("result shown while loading");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ITEM_CAP))
		else $error("item count beyond capacity");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP || state_q == S_SWAP) |-> (slot_q <= j_q && j_q < count_q))
		else $error("scan pointers out of order");

	a_result_has_items: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> count_q != '0)
		else $error("result with empty list");
`endif

endmodule
